@@ rtl/hpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hpc_pkg;

   localparam int TIME_W      = 32;
   localparam int PCT_W       = 7;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   localparam int PCT_SCALE = 100;

   localparam int AIR_RESET      = 3400;
   localparam int WATER_RESET    = 1400;
   localparam int DRY_RESET      = 35;
   localparam int WET_RESET      = 65;
   localparam int MAX_RUN_RESET  = 10000;
   localparam int COOLDOWN_RESET = 300000;
   localparam int RISE_RESET     = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AIR_VALUE     = 3'd0,
      CSR_WATER_VALUE   = 3'd1,
      CSR_DRY_THRESHOLD = 3'd2,
      CSR_WET_THRESHOLD = 3'd3,
      CSR_MAX_RUN_MS    = 3'd4,
      CSR_COOLDOWN_MS   = 3'd5,
      CSR_TANK_LOW_RISE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/hpc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface hpc_req_if #(parameter int ADC_BITS = 12) ();
   logic                             valid;
   logic                             ready;
   logic [ADC_BITS-1:0]              raw_sample;
   logic [hpc_pkg::TIME_W-1:0]       now_ms;

   modport source (output valid, output raw_sample, output now_ms, input ready);
   modport sink (input valid, input raw_sample, input now_ms, output ready);
endinterface

interface hpc_rsp_if ();
   logic                             valid;
   logic                             ready;
   logic [hpc_pkg::PCT_W-1:0]        moisture_pct;
   logic                             pump_on;
   logic                             tank_low;

   modport source (output valid, output moisture_pct, output pump_on, output tank_low,
                   input ready);
   modport sink (input valid, input moisture_pct, input pump_on, input tank_low,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/hpc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hpc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire hpc_pkg::status_type  status,
   output hpc_pkg::cmd_type          cmd
);

   hpc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         hpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = hpc_pkg::ST_DIVIDE;
            end
         end
         hpc_pkg::ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = hpc_pkg::ST_UPDATE;
            end
         end
         hpc_pkg::ST_UPDATE: begin
            // The result register must be free before the state is committed.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = hpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (state_ff == hpc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/hpc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hpc_datapath #(
   parameter int ADC_BITS = 12
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hpc_pkg::cmd_type                   cmd,
   output hpc_pkg::status_type                     status,
   input  wire logic [ADC_BITS-1:0]                req_raw_sample,
   input  wire logic [hpc_pkg::TIME_W-1:0]         req_now_ms,
   input  wire logic                               csr_wr_en,
   input  wire logic [hpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [hpc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [hpc_pkg::PCT_W-1:0]               rsp_moisture_pct,
   output logic                                    rsp_pump_on,
   output logic                                    rsp_tank_low
);

   // The numerator |raw - air| * 100 needs ADC_BITS + 7 bits.
   localparam int NW = ADC_BITS + 7;
   localparam int CW = $clog2(NW);
   localparam int TW = hpc_pkg::TIME_W;
   localparam int PW = hpc_pkg::PCT_W;

   // Configuration registers.
   logic [ADC_BITS-1:0] air_ff, air_in, water_ff, water_in;
   logic [PW-1:0]       dry_ff, dry_in, wet_ff, wet_in, rise_ff, rise_in;
   logic [TW-1:0]       max_run_ff, max_run_in, cooldown_ff, cooldown_in;

   // Controller state.
   logic                running_ff, running_in;
   logic [TW-1:0]       run_start_ff, run_start_in;
   logic [TW-1:0]       last_end_ff, last_end_in;
   logic                tank_ff, tank_in;
   logic [PW-1:0]       start_pct_ff, start_pct_in;

   // Per-item working registers.
   logic [TW-1:0]       now_ff, now_in;
   logic [NW-1:0]       num_ff, num_in;
   logic [ADC_BITS-1:0] rem_ff, rem_in;
   logic [ADC_BITS-1:0] den_ff, den_in;
   logic                pos_ff, pos_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                cool_ok_ff, cool_ok_in;
   logic                run_to_ff, run_to_in;

   // Result registers.
   logic [PW-1:0]       pct_out_ff, pct_out_in;
   logic                pump_out_ff, pump_out_in;
   logic                tank_out_ff, tank_out_in;

   logic signed [ADC_BITS:0] diff, span;
   logic [ADC_BITS-1:0]      diff_mag, span_mag;
   logic [NW-1:0]            num_load;
   logic [ADC_BITS:0]        trial, trial_sub;
   logic                     trial_ge;
   logic [TW-1:0]            since_end, since_start;
   logic [PW-1:0]            pct;
   logic                     start, run_now, timeout, stop;
   logic [PW-1:0]            start_pct_sel;
   logic [PW:0]              rise_limit;
   logic                     low_rise;

   // Mapping operands, formed when an item is taken in.
   assign diff     = $signed({1'b0, req_raw_sample}) - $signed({1'b0, air_ff});
   assign span     = $signed({1'b0, water_ff}) - $signed({1'b0, air_ff});
   assign diff_mag = diff[ADC_BITS] ? ADC_BITS'(-diff) : diff[ADC_BITS-1:0];
   assign span_mag = span[ADC_BITS] ? ADC_BITS'(-span) : span[ADC_BITS-1:0];
   assign num_load = NW'(diff_mag) * NW'(hpc_pkg::PCT_SCALE);

   // One restoring division step per cycle; quotient bits shift into num_ff.
   assign trial     = {rem_ff, num_ff[NW-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign trial_ge  = (trial >= {1'b0, den_ff});

   assign since_end   = now_ff - last_end_ff;
   assign since_start = now_ff - run_start_ff;

   // A negative or zero quotient, or equal calibration points, clamps to zero.
   always_comb begin
      if (!pos_ff) begin
         pct = '0;
      end else if (num_ff > NW'(hpc_pkg::PCT_SCALE)) begin
         pct = PW'(hpc_pkg::PCT_SCALE);
      end else begin
         pct = num_ff[PW-1:0];
      end
   end

   always_comb begin
      start   = !running_ff && (pct < dry_ff) && cool_ok_ff;
      run_now = running_ff || start;
      // A pump that starts in this step has zero elapsed run time.
      timeout = running_ff ? run_to_ff : (max_run_ff == '0);
      stop    = run_now && ((pct > wet_ff) || timeout);
      start_pct_sel = start ? pct : start_pct_ff;
      // pct - start < rise is evaluated as pct < start + rise.
      rise_limit = {1'b0, start_pct_sel} + {1'b0, rise_ff};
      low_rise   = ({1'b0, pct} < rise_limit);
   end

   always_comb begin
      air_in      = air_ff;
      water_in    = water_ff;
      dry_in      = dry_ff;
      wet_in      = wet_ff;
      rise_in     = rise_ff;
      max_run_in  = max_run_ff;
      cooldown_in = cooldown_ff;
      if (csr_wr_en) begin
         unique case (hpc_pkg::csr_index_type'(csr_index))
            hpc_pkg::CSR_AIR_VALUE:     air_in      = csr_wdata[ADC_BITS-1:0];
            hpc_pkg::CSR_WATER_VALUE:   water_in    = csr_wdata[ADC_BITS-1:0];
            hpc_pkg::CSR_DRY_THRESHOLD: dry_in      = csr_wdata[PW-1:0];
            hpc_pkg::CSR_WET_THRESHOLD: wet_in      = csr_wdata[PW-1:0];
            hpc_pkg::CSR_MAX_RUN_MS:    max_run_in  = csr_wdata[TW-1:0];
            hpc_pkg::CSR_COOLDOWN_MS:   cooldown_in = csr_wdata[TW-1:0];
            hpc_pkg::CSR_TANK_LOW_RISE: rise_in     = csr_wdata[PW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      now_in  = now_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         now_in = req_now_ms;
         num_in = num_load;
         rem_in = '0;
         den_in = span_mag;
         pos_in = (span != '0) && (diff[ADC_BITS] == span[ADC_BITS]);
         cnt_in = '0;
      end else if (cmd.step) begin
         num_in = {num_ff[NW-2:0], trial_ge};
         rem_in = trial_ge ? trial_sub[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
         cnt_in = cnt_ff + CW'(1);
      end
      // These only depend on the held time and the state, so they settle
      // during the division and are read in the update cycle.
      cool_ok_in = (since_end >= cooldown_ff);
      run_to_in  = (since_start >= max_run_ff);
   end

   always_comb begin
      running_in   = running_ff;
      run_start_in = run_start_ff;
      last_end_in  = last_end_ff;
      tank_in      = tank_ff;
      start_pct_in = start_pct_ff;
      pct_out_in   = pct_out_ff;
      pump_out_in  = pump_out_ff;
      tank_out_in  = tank_out_ff;
      if (cmd.commit) begin
         running_in   = run_now && !stop;
         start_pct_in = start_pct_sel;
         if (start) begin
            run_start_in = now_ff;
         end
         if (stop) begin
            last_end_in = now_ff;
            tank_in     = timeout && low_rise;
         end
         pct_out_in  = pct;
         pump_out_in = run_now && !stop;
         tank_out_in = stop ? (timeout && low_rise) : tank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         air_ff       <= ADC_BITS'(hpc_pkg::AIR_RESET);
         water_ff     <= ADC_BITS'(hpc_pkg::WATER_RESET);
         dry_ff       <= PW'(hpc_pkg::DRY_RESET);
         wet_ff       <= PW'(hpc_pkg::WET_RESET);
         rise_ff      <= PW'(hpc_pkg::RISE_RESET);
         max_run_ff   <= TW'(hpc_pkg::MAX_RUN_RESET);
         cooldown_ff  <= TW'(hpc_pkg::COOLDOWN_RESET);
         running_ff   <= 1'b0;
         run_start_ff <= '0;
         last_end_ff  <= '0;
         tank_ff      <= 1'b0;
         start_pct_ff <= '0;
         cnt_ff       <= '0;
      end else begin
         air_ff       <= air_in;
         water_ff     <= water_in;
         dry_ff       <= dry_in;
         wet_ff       <= wet_in;
         rise_ff      <= rise_in;
         max_run_ff   <= max_run_in;
         cooldown_ff  <= cooldown_in;
         running_ff   <= running_in;
         run_start_ff <= run_start_in;
         last_end_ff  <= last_end_in;
         tank_ff      <= tank_in;
         start_pct_ff <= start_pct_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      pos_ff      <= pos_in;
      cool_ok_ff  <= cool_ok_in;
      run_to_ff   <= run_to_in;
      pct_out_ff  <= pct_out_in;
      pump_out_ff <= pump_out_in;
      tank_out_ff <= tank_out_in;
   end

   assign status.div_done  = (cnt_ff == CW'(NW - 1));
   assign rsp_moisture_pct = pct_out_ff;
   assign rsp_pump_on      = pump_out_ff;
   assign rsp_tank_low     = tank_out_ff;

endmodule

`default_nettype wire

@@ rtl/hysteresis_pump_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Moisture pump controller. Each request transfer carries a raw ADC sample and
// the current millisecond time; each produces exactly one response transfer with
// the clamped moisture percentage and the pump and tank-low flags after the step.
// An item passes from its request transfer through the bit-serial restoring
// divider that maps the sample to a percentage, then through an update state,
// which is held for as long as the previous response still waits in its output
// register. The block handles one item at a time and takes the next request in
// the cycle after the update. Configuration registers are written through the
// csr_ port; the user must write them only while no item is in flight, as the
// block itself does not enforce it.

module hysteresis_pump_controller #(
   parameter int ADC_BITS = 12
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   hpc_req_if.sink                                 req_if,
   hpc_rsp_if.source                               rsp_if,
   input  wire logic                               csr_wr_en,
   input  wire logic [hpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [hpc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   hpc_pkg::cmd_type    cmd;
   hpc_pkg::status_type status;
   logic                req_ready;
   logic                rsp_valid;

   hpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hpc_datapath #(
      .ADC_BITS (ADC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_raw_sample   (req_if.raw_sample),
      .req_now_ms       (req_if.now_ms),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_moisture_pct (rsp_if.moisture_pct),
      .rsp_pump_on      (rsp_if.pump_on),
      .rsp_tank_low     (rsp_if.tank_low)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

`ifndef SYNTH
   // Once an item is taken in, no other is accepted until it has been processed.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while an item is in progress");

   // A committed step always presents a response in the next cycle.
   a_commit_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_if.valid)
      else $error("committed step did not produce a response");

   // The controller issues at most one command per cycle.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.commit}))
      else $error("controller issued overlapping commands");

   // The clamp keeps the reported percentage within range.
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.moisture_pct <= hpc_pkg::PCT_W'(hpc_pkg::PCT_SCALE)))
      else $error("moisture percentage above 100");
`endif

endmodule

`default_nettype wire

@@ bench/pump_response_checker.sv @@
`timescale 1ns / 1ps

module pump_response_checker
   import hpc_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [ADC_BITS-1:0]    req_raw_sample,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [PCT_W-1:0]       rsp_moisture_pct,
   input  logic                   rsp_pump_on,
   input  logic                   rsp_tank_low,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     outstanding
);

   typedef struct packed {
      logic [PCT_W-1:0] moisture_pct;
      logic             pump_on;
      logic             tank_low;
   } pump_reading_type;

   logic [ADC_BITS-1:0] air_cal;
   logic [ADC_BITS-1:0] water_cal;
   logic [PCT_W-1:0]    dry_level;
   logic [PCT_W-1:0]    wet_level;
   logic [TIME_W-1:0]   max_run_ms;
   logic [TIME_W-1:0]   cooldown_ms;
   logic [PCT_W-1:0]    tank_low_rise;

   logic                pump_running;
   logic [TIME_W-1:0]   run_start_time;
   logic [TIME_W-1:0]   last_cycle_end;
   logic                tank_low_flag;
   logic [PCT_W-1:0]    start_moisture;

   pump_reading_type    expected_readings[$];
   pump_reading_type    observed;
   pump_reading_type    predicted;
   int                  errors = 0;
   int                  response_number = 0;

   // Linear map between the calibration points; integer division truncates
   // toward zero, as the block does.
   function automatic logic [PCT_W-1:0] moisture_percent(input logic [ADC_BITS-1:0] raw);
      int span;
      int scaled;
      int pct;
      span = int'(water_cal) - int'(air_cal);
      if (span == 0) begin
         return '0;
      end
      scaled = (int'(raw) - int'(air_cal)) * PCT_SCALE;
      pct = scaled / span;
      if (pct < 0) begin
         pct = 0;
      end
      if (pct > PCT_SCALE) begin
         pct = PCT_SCALE;
      end
      return pct[PCT_W-1:0];
   endfunction

   function automatic pump_reading_type advance_pump(input logic [ADC_BITS-1:0] raw,
                                                     input logic [TIME_W-1:0] now);
      logic [PCT_W-1:0] pct;
      logic [TIME_W-1:0] since_end;
      logic [TIME_W-1:0] since_start;
      logic wet;
      logic timed_out;
      int rise;
      pump_reading_type reading;
      pct = moisture_percent(raw);
      since_end = now - last_cycle_end;
      if (!pump_running && pct < dry_level && since_end >= cooldown_ms) begin
         start_moisture = pct;
         run_start_time = now;
         pump_running = 1'b1;
      end
      // A pump that just started is checked for a stop in the same step.
      if (pump_running) begin
         since_start = now - run_start_time;
         wet = pct > wet_level;
         timed_out = since_start >= max_run_ms;
         if (wet || timed_out) begin
            rise = int'(pct) - int'(start_moisture);
            pump_running = 1'b0;
            last_cycle_end = now;
            tank_low_flag = timed_out && (rise < int'(tank_low_rise));
         end
      end
      reading.moisture_pct = pct;
      reading.pump_on = pump_running;
      reading.tank_low = tank_low_flag;
      return reading;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         air_cal = ADC_BITS'(AIR_RESET);
         water_cal = ADC_BITS'(WATER_RESET);
         dry_level = PCT_W'(DRY_RESET);
         wet_level = PCT_W'(WET_RESET);
         max_run_ms = TIME_W'(MAX_RUN_RESET);
         cooldown_ms = TIME_W'(COOLDOWN_RESET);
         tank_low_rise = PCT_W'(RISE_RESET);
         pump_running = 1'b0;
         run_start_time = '0;
         last_cycle_end = '0;
         tank_low_flag = 1'b0;
         start_moisture = '0;
         expected_readings.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_AIR_VALUE:     air_cal = csr_wdata[ADC_BITS-1:0];
               CSR_WATER_VALUE:   water_cal = csr_wdata[ADC_BITS-1:0];
               CSR_DRY_THRESHOLD: dry_level = csr_wdata[PCT_W-1:0];
               CSR_WET_THRESHOLD: wet_level = csr_wdata[PCT_W-1:0];
               CSR_MAX_RUN_MS:    max_run_ms = csr_wdata[TIME_W-1:0];
               CSR_COOLDOWN_MS:   cooldown_ms = csr_wdata[TIME_W-1:0];
               CSR_TANK_LOW_RISE: tank_low_rise = csr_wdata[PCT_W-1:0];
               default: ;
            endcase
         end
         // The response leaving now belongs to an older request, so it is
         // matched before a request accepted at the same edge is predicted.
         if (rsp_valid && rsp_ready) begin
            observed.moisture_pct = rsp_moisture_pct;
            observed.pump_on = rsp_pump_on;
            observed.tank_low = rsp_tank_low;
            if (expected_readings.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("response %0d: none expected, got pct %0d pump %0b tank %0b",
                           response_number, observed.moisture_pct, observed.pump_on,
                           observed.tank_low);
               end
            end else begin
               predicted = expected_readings.pop_front();
               if (observed.moisture_pct !== predicted.moisture_pct ||
                   observed.pump_on !== predicted.pump_on ||
                   observed.tank_low !== predicted.tank_low) begin
                  errors++;
                  if (errors <= 10) begin
                     $display({"response %0d: expected pct %0d pump %0b tank %0b, ",
                               "got pct %0d pump %0b tank %0b"},
                              response_number, predicted.moisture_pct, predicted.pump_on,
                              predicted.tank_low, observed.moisture_pct, observed.pump_on,
                              observed.tank_low);
                  end
               end
            end
            response_number++;
         end
         if (req_valid && req_ready) begin
            expected_readings.push_back(advance_pump(req_raw_sample, req_now_ms));
         end
      end
      mismatch_count <= errors;
      outstanding <= expected_readings.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import hpc_pkg::*;

   localparam int ADC_BITS = 12;
   localparam int RESPONSE_LATENCY = ADC_BITS + 9;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int PHASE_COUNT = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     sender_idle_pct = 0;
   int                     receiver_stall_pct = 0;
   logic [TIME_W-1:0]      clock_ms;
   int                     mismatch_count;
   int                     outstanding;

   hpc_req_if #(.ADC_BITS(ADC_BITS)) req_ch ();
   hpc_rsp_if rsp_ch ();

   hysteresis_pump_controller #(.ADC_BITS(ADC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pump_response_checker #(.ADC_BITS(ADC_BITS)) pump_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_raw_sample   (req_ch.raw_sample),
      .req_now_ms       (req_ch.now_ms),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_moisture_pct (rsp_ch.moisture_pct),
      .rsp_pump_on      (rsp_ch.pump_on),
      .rsp_tank_low     (rsp_ch.tank_low),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;
            receiver_stall_pct <= 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 60;
            receiver_stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            receiver_stall_pct <= 60;
         end
         default: begin
            sender_idle_pct = 35;
            receiver_stall_pct <= 35;
         end
      endcase
   endtask

   // Returns at the edge where the request transfer took place.
   task automatic send_sample(input logic [ADC_BITS-1:0] raw, input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.raw_sample <= raw;
      req_ch.now_ms <= now;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [ADC_BITS-1:0] air, input logic [ADC_BITS-1:0] water,
                            input logic [PCT_W-1:0] dry, input logic [PCT_W-1:0] wet,
                            input logic [TIME_W-1:0] max_run, input logic [TIME_W-1:0] cooldown,
                            input logic [PCT_W-1:0] rise);
      write_register(CSR_AIR_VALUE, CSR_DATA_W'(air));
      write_register(CSR_WATER_VALUE, CSR_DATA_W'(water));
      write_register(CSR_DRY_THRESHOLD, CSR_DATA_W'(dry));
      write_register(CSR_WET_THRESHOLD, CSR_DATA_W'(wet));
      write_register(CSR_MAX_RUN_MS, CSR_DATA_W'(max_run));
      write_register(CSR_COOLDOWN_MS, CSR_DATA_W'(cooldown));
      write_register(CSR_TANK_LOW_RISE, CSR_DATA_W'(rise));
      // A write past the register list must leave every setting alone.
      write_register(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom()));
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (RESPONSE_LATENCY) @(posedge clock);
   endtask

   function automatic logic [TIME_W-1:0] random_duration();
      case ($urandom_range(9))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2, 3: return TIME_W'($urandom_range(1, 100));
         default: return TIME_W'($urandom_range(1000, 60000));
      endcase
   endfunction

   function automatic logic [PCT_W-1:0] random_threshold();
      case ($urandom_range(7))
         0: return '0;
         1: return PCT_W'(PCT_SCALE);
         2: return PCT_W'($urandom_range(PCT_SCALE + 1, 127));
         default: return PCT_W'($urandom_range(0, PCT_SCALE));
      endcase
   endfunction

   task automatic random_config;
      logic [ADC_BITS-1:0] air;
      logic [ADC_BITS-1:0] water;
      case ($urandom_range(7))
         0: begin
            air = ADC_BITS'($urandom());
            water = air;
         end
         1, 2: begin
            air = ADC_BITS'($urandom());
            water = ADC_BITS'($urandom());
         end
         3: begin
            // Reading rises with moisture.
            air = ADC_BITS'($urandom_range(0, 1500));
            water = ADC_BITS'($urandom_range(2500, 4095));
         end
         default: begin
            air = ADC_BITS'($urandom_range(2500, 4095));
            water = ADC_BITS'($urandom_range(0, 1500));
         end
      endcase
      configure(air, water, random_threshold(), random_threshold(), random_duration(),
                random_duration(), random_threshold());
   endtask

   // Time mostly moves forward in modest steps so that cooldowns and runtime
   // limits expire; now and then it jumps anywhere.
   function automatic logic [TIME_W-1:0] time_step();
      case ($urandom_range(15))
         0: return TIME_W'($urandom());
         1, 2: return TIME_W'($urandom_range(0, 10));
         3: return TIME_W'($urandom_range(0, 300));
         default: return TIME_W'($urandom_range(0, 20000));
      endcase
   endfunction

   function automatic logic [ADC_BITS-1:0] random_sample();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return ADC_BITS'($urandom());
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.raw_sample = '0;
      req_ch.now_ms = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings after reset: clamping at both ends, cooldown not yet over,
      // a timeout with no rise, a wet stop, and a run across the time wrap.
      set_idle_mode(IDLE_NONE);
      send_sample(12'd0, 32'd0);
      send_sample(12'd4095, 32'd1000);
      send_sample(12'd3400, 32'd300000);
      send_sample(12'd2400, 32'd305000);
      send_sample(12'd3400, 32'd310000);
      send_sample(12'd1400, 32'd320000);
      send_sample(12'd4095, 32'd610000);
      send_sample(12'd0, 32'd611000);
      send_sample(12'd3000, 32'hFFFF_0000);
      send_sample(12'd3000, 32'h0000_1000);
      drain();

      // Equal calibration points, thresholds above 100, zero runtime limit:
      // the pump starts and stops in the same step.
      configure(12'd2000, 12'd2000, 7'd127, 7'd127, 32'd0, 32'd0, 7'd127);
      send_sample(12'd0, 32'd5);
      send_sample(12'd4095, 32'd6);
      send_sample(12'd2000, 32'd7);
      drain();

      // Rising map with a reading both below dry and above wet.
      configure(12'd0, 12'd4095, 7'd100, 7'd0, 32'hFFFF_FFFF, 32'd0, 7'd0);
      send_sample(12'd2048, 32'd100);
      send_sample(12'd0, 32'd200);
      send_sample(12'd4095, 32'd300);
      drain();

      // Moisture falls during the run, so the rise at the timeout is negative.
      configure(12'd0, 12'd4095, 7'd100, 7'd100, 32'd10, 32'd0, 7'd0);
      send_sample(12'd2000, 32'd1000);
      send_sample(12'd1000, 32'd1020);
      drain();

      clock_ms = $urandom();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: configure(ADC_BITS'(AIR_RESET), ADC_BITS'(WATER_RESET), PCT_W'(DRY_RESET),
                         PCT_W'(WET_RESET), TIME_W'(MAX_RUN_RESET), TIME_W'(COOLDOWN_RESET),
                         PCT_W'(RISE_RESET));
            1: configure('1, '0, PCT_W'(PCT_SCALE), PCT_W'(PCT_SCALE), 32'hFFFF_FFFF, 32'd0,
                         PCT_W'(PCT_SCALE));
            2: configure('0, '0, '0, '0, '0, '0, '0);
            default: random_config();
         endcase
         set_idle_mode(idle_mode_type'(phase % 4));
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            clock_ms = clock_ms + time_step();
            send_sample(random_sample(), clock_ms);
         end
         drain();
      end

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ hysteresis_pump_controller.f @@
rtl/hpc_pkg.sv
rtl/hpc_if.sv
rtl/hpc_ctrl.sv
rtl/hpc_datapath.sv
rtl/hysteresis_pump_controller.sv
bench/pump_response_checker.sv
bench/testbench.sv
